// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, removable by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, codes and constants of the triangle point sampler.
// ----------------------------------------------------------------------------
package tps_pkg;

	localparam int VERTEX_DEPTH_DEF = 4096;
	localparam int FACET_DEPTH_DEF  = 4096;
	localparam int REF_W   = 12;
	localparam int POS_W   = 32;
	localparam int NRM_W   = 16;
	localparam int SMP_W   = 16;
	localparam int WGT_W   = 17;
	localparam int ACC_W   = 50;
	localparam int VTX_W   = 3 * POS_W + 3 * NRM_W;
	localparam int FCT_W   = 3 * REF_W;
	localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

	typedef enum logic [1:0] {
		OP_VTX = 2'd0,
		OP_FCT = 2'd1,
		OP_SMP = 2'd2,
		OP_NOP = 2'd3
	} tps_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FRMW,
		ST_FCAP,
		ST_SQRT,
		ST_WGT,
		ST_VRD,
		ST_MAC,
		ST_OUT
	} tps_state_t;

endpackage

// File: hw/rtl/tps_if.sv
// ----------------------------------------------------------------------------
// tps_req_if / tps_rsp_if
// Valid/ready channels carrying sampler request and result beats.
// ----------------------------------------------------------------------------
interface tps_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  op;
	logic        [11:0] index;
	logic        [1:0]  corner;
	logic        [11:0] vertex_ref;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] nrm_x;
	logic signed [15:0] nrm_y;
	logic signed [15:0] nrm_z;
	logic        [15:0] sample_u;
	logic        [15:0] sample_v;

	modport source (output valid, op, index, corner, vertex_ref, pos_x, pos_y, pos_z,
		nrm_x, nrm_y, nrm_z, sample_u, sample_v, input ready);
	modport sink (input valid, op, index, corner, vertex_ref, pos_x, pos_y, pos_z,
		nrm_x, nrm_y, nrm_z, sample_u, sample_v, output ready);
endinterface

interface tps_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic               normal_valid;

	modport source (output valid, point_x, point_y, point_z, normal_x, normal_y,
		normal_z, normal_valid, input ready);
	modport sink (input valid, point_x, point_y, point_z, normal_x, normal_y,
		normal_z, normal_valid, output ready);
endinterface

// File: hw/rtl/tps_ram.sv
// ----------------------------------------------------------------------------
// tps_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/tps_isqrt.sv
// ----------------------------------------------------------------------------
// tps_isqrt
// Bit-serial integer square root of x * 65536, one result bit per cycle.
// ----------------------------------------------------------------------------
module tps_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tps_pkg::WGT_W-1:0] x,
	output logic                      done,
	output logic [tps_pkg::WGT_W-1:0] root
);
	import tps_pkg::*;

	logic [32:0] n_q;
	logic [33:0] r_q;
	logic [32:0] bit_q;
	logic        busy_q;
	logic [33:0] trial;

	assign trial = r_q + {1'b0, bit_q};
	assign done  = busy_q && (bit_q == '0);
	assign root  = r_q[WGT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {x, 16'h0000};
			r_q   <= '0;
			bit_q <= 33'h1_0000_0000;
		end else if (busy_q && (bit_q != '0)) begin
			if ({1'b0, n_q} >= trial) begin
				n_q <= n_q - trial[32:0];
				r_q <= (r_q >> 1) + {1'b0, bit_q};
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// File: hw/rtl/triangle_point_sampler.sv
// ----------------------------------------------------------------------------
// triangle_point_sampler
// Uniform point sampling on mesh facets held in on-chip vertex/facet RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per command: op 0 loads a vertex (position and
//   normal), op 1 loads one corner reference of a facet, op 2 samples a
//   point on a facet from u and v; op 3 is dropped. Only op 2 yields a
//   beat on rsp. cfg_wr_en/cfg_wr_data set normals_present; the user must
//   write it only while idle, as the block itself does not enforce this.
//   Vertex loads and dropped ops complete in the idle state; facet
//   corner loads do a read-modify-write of the facet word; samples run
//   a facet read, a bit-serial square root, weights, then three vertex
//   RAM reads, each followed by six passes of the one shared
//   multiply-accumulate unit, then the output load. One item is worked
//   on at a time; req.ready is high only between items.
//   Reset clears the sequencer, the result valid flag and normals_present;
//   table contents are undefined until loaded.
//   A stalled receiver holds the result in the output register; the next
//   command is still taken, and a following sample waits in its last
//   step until the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_point_sampler #(
	parameter int VERTEX_DEPTH = tps_pkg::VERTEX_DEPTH_DEF,
	parameter int FACET_DEPTH  = tps_pkg::FACET_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	tps_req_if.sink   req,
	tps_rsp_if.source rsp
);
	import tps_pkg::*;

	localparam int VA_W = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int FA_W = (FACET_DEPTH > 1) ? $clog2(FACET_DEPTH) : 1;

	tps_state_t state_q, state_d;

	logic              normals_q;
	logic              accept;
	logic [31:0]       idx_ext;
	logic              vidx_ok, fidx_ok;

	logic              vtx_we, vtx_re;
	logic [VA_W-1:0]   vtx_waddr, vtx_raddr;
	logic [VTX_W-1:0]  vtx_wdata, vtx_rdata;
	logic              fct_we, fct_re;
	logic [FA_W-1:0]   fct_waddr, fct_raddr;
	logic [FCT_W-1:0]  fct_wdata, fct_rdata;

	logic [FA_W-1:0]   faddr_q;
	logic [1:0]        corner_q;
	logic [REF_W-1:0]  vref_q;
	logic              fok_q;
	logic [SMP_W-1:0]  u_q, v_q;
	logic [REF_W-1:0]  refs_q [3];
	logic [2:0]        rok_q;

	logic              sq_start, sq_done;
	logic [WGT_W-1:0]  sq_x, sq_root;
	logic [WGT_W-1:0]  s_q, alpha_q, beta_q, gamma_q;
	logic [32:0]       vs_prod;
	logic [WGT_W-1:0]  beta_d;

	logic [1:0]        k_q;
	logic [2:0]        c_q;
	logic              vzero_q;
	logic [WGT_W-1:0]  wsel;
	logic signed [31:0] vsel;
	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] acc_q [6];

	logic              out_load;
	logic              rsp_valid_q;

	assign accept  = req.valid && req.ready;
	assign idx_ext = {20'h00000, req.index};
	assign vidx_ok = idx_ext < 32'(VERTEX_DEPTH);
	assign fidx_ok = idx_ext < 32'(FACET_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normals_q <= 1'b0;
		end else if (cfg_wr_en) begin
			normals_q <= cfg_wr_data;
		end
	end

	tps_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_DEPTH)) u_vtx_ram (
		.clk   (clk),
		.we    (vtx_we),
		.waddr (vtx_waddr),
		.wdata (vtx_wdata),
		.re    (vtx_re),
		.raddr (vtx_raddr),
		.rdata (vtx_rdata)
	);

	tps_ram #(.WIDTH(FCT_W), .DEPTH(FACET_DEPTH)) u_fct_ram (
		.clk   (clk),
		.we    (fct_we),
		.waddr (fct_waddr),
		.wdata (fct_wdata),
		.re    (fct_re),
		.raddr (fct_raddr),
		.rdata (fct_rdata)
	);

	tps_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (sq_x),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign vtx_we    = accept && (tps_op_t'(req.op) == OP_VTX) && vidx_ok;
	assign vtx_waddr = idx_ext[VA_W-1:0];
	assign vtx_wdata = {req.nrm_z, req.nrm_y, req.nrm_x, req.pos_z, req.pos_y, req.pos_x};
	assign vtx_re    = (state_q == ST_VRD);

	always_comb begin
		logic [31:0] ref_ext;
		ref_ext   = {20'h00000, refs_q[k_q]};
		vtx_raddr = ref_ext[VA_W-1:0];
	end

	assign fct_re    = accept && ((tps_op_t'(req.op) == OP_FCT) || (tps_op_t'(req.op) == OP_SMP));
	assign fct_raddr = idx_ext[FA_W-1:0];
	assign fct_we    = (state_q == ST_FRMW);
	assign fct_waddr = faddr_q;

	always_comb begin
		fct_wdata = fct_rdata;
		case (corner_q)
			2'd0:    fct_wdata[0*REF_W +: REF_W] = vref_q;
			2'd1:    fct_wdata[1*REF_W +: REF_W] = vref_q;
			default: fct_wdata[2*REF_W +: REF_W] = vref_q;
		endcase
	end

	assign sq_start = (state_q == ST_FCAP);
	assign sq_x     = ONE_Q16 - {1'b0, u_q};
	assign vs_prod  = {1'b0, v_q} * {16'h0000, s_q};
	assign beta_d   = vs_prod[32:16];

	always_comb begin
		unique case (k_q)
			2'd0:    wsel = gamma_q;
			2'd1:    wsel = alpha_q;
			default: wsel = beta_q;
		endcase
		unique case (c_q)
			3'd0:    vsel = vtx_rdata[31:0];
			3'd1:    vsel = vtx_rdata[63:32];
			3'd2:    vsel = vtx_rdata[95:64];
			3'd3:    vsel = 32'(signed'(vtx_rdata[111:96]));
			3'd4:    vsel = 32'(signed'(vtx_rdata[127:112]));
			default: vsel = 32'(signed'(vtx_rdata[143:128]));
		endcase
		if (vzero_q) begin
			vsel = '0;
		end
	end

	assign prod = ACC_W'(signed'({1'b0, wsel})) * ACC_W'(vsel);

	assign out_load = (state_q == ST_OUT) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (tps_op_t'(req.op))
						OP_FCT:  if (fidx_ok && (req.corner != 2'd3)) state_d = ST_FRMW;
						OP_SMP:  state_d = ST_FCAP;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FRMW: state_d = ST_IDLE;
			ST_FCAP: state_d = ST_SQRT;
			ST_SQRT: if (sq_done) state_d = ST_WGT;
			ST_WGT:  state_d = ST_VRD;
			ST_VRD:  state_d = ST_MAC;
			ST_MAC: begin
				if (c_q == 3'd5) begin
					state_d = (k_q == 2'd2) ? ST_OUT : ST_VRD;
				end
			end
			ST_OUT:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			faddr_q  <= idx_ext[FA_W-1:0];
			corner_q <= req.corner;
			vref_q   <= req.vertex_ref;
			fok_q    <= fidx_ok;
			u_q      <= req.sample_u;
			v_q      <= req.sample_v;
		end
		if (state_q == ST_FCAP) begin
			for (int i = 0; i < 3; i++) begin
				refs_q[i] <= fct_rdata[i*REF_W +: REF_W];
				rok_q[i]  <= fok_q &&
					({20'h00000, fct_rdata[i*REF_W +: REF_W]} < 32'(VERTEX_DEPTH));
			end
		end
		if ((state_q == ST_SQRT) && sq_done) begin
			s_q <= sq_root;
		end
		if (state_q == ST_WGT) begin
			alpha_q <= ONE_Q16 - s_q;
			beta_q  <= beta_d;
			gamma_q <= s_q - beta_d;
			k_q     <= 2'd0;
			for (int i = 0; i < 6; i++) begin
				acc_q[i] <= '0;
			end
		end
		if (state_q == ST_VRD) begin
			vzero_q <= !rok_q[k_q];
			c_q     <= 3'd0;
		end
		if (state_q == ST_MAC) begin
			acc_q[c_q] <= acc_q[c_q] + prod;
			c_q        <= c_q + 3'd1;
			if (c_q == 3'd5) begin
				k_q <= k_q + 2'd1;
			end
		end
		if (out_load) begin
			rsp.point_x      <= acc_q[0][47:16];
			rsp.point_y      <= acc_q[1][47:16];
			rsp.point_z      <= acc_q[2][47:16];
			rsp.normal_x     <= normals_q ? acc_q[3][31:16] : 16'sh0000;
			rsp.normal_y     <= normals_q ? acc_q[4][31:16] : 16'sh0000;
			rsp.normal_z     <= normals_q ? acc_q[5][31:16] : 16'sh0000;
			rsp.normal_valid <= normals_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = rsp_valid_q;

	`ASSERT_IMPLY(a_root_range, clk, arst_n, (state_q == ST_SQRT) && sq_done,
		(sq_root >= 17'd256) && (sq_root <= ONE_Q16))
	`ASSERT_IMPLY(a_weight_sum, clk, arst_n, state_q == ST_VRD,
		(18'(alpha_q) + 18'(beta_q) + 18'(gamma_q)) == 18'(ONE_Q16))
	`ASSERT_IMPLY(a_rsp_source, clk, arst_n, $rose(rsp.valid), $past(state_q) == ST_OUT)
	`ASSERT_NEXT(a_frmw_once, clk, arst_n, state_q == ST_FRMW, state_q == ST_IDLE)

endmodule

// File: tb/tps_tb_pkg.sv
// ----------------------------------------------------------------------------
// tps_tb_pkg
// Sample predictor and result scoreboard for the triangle point sampler.
// ----------------------------------------------------------------------------
package tps_tb_pkg;
	import tps_pkg::*;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               nv;
	} point_t;

	typedef struct {
		logic        [1:0]  op;
		logic        [11:0] index;
		logic        [1:0]  corner;
		logic        [11:0] vertex_ref;
		logic signed [31:0] pos [3];
		logic signed [15:0] nrm [3];
		logic        [15:0] u;
		logic        [15:0] v;
	} cmd_t;

	class point_scoreboard;
		logic signed [31:0] pos_tab [4096][3];
		logic signed [15:0] nrm_tab [4096][3];
		logic        [11:0] corner_tab [4096][3];
		bit                 normals_on;
		point_t             pending [$];
		int                 errors;

		function automatic longint floor16(longint acc);
			return acc >>> 16;
		endfunction

		function automatic longint root_q16(longint n);
			longint r;
			r = $rtoi($sqrt(real'(n)));
			while (r * r > n) r--;
			while ((r + 1) * (r + 1) <= n) r++;
			return r;
		endfunction

		function void note_command(cmd_t c);
			longint s, a, b, g, acc;
			logic [11:0] vr [3];
			point_t p;
			case (tps_op_t'(c.op))
				OP_VTX: begin
					for (int k = 0; k < 3; k++) begin
						pos_tab[c.index][k] = c.pos[k];
						nrm_tab[c.index][k] = c.nrm[k];
					end
				end
				OP_FCT: begin
					if (c.corner < 3) corner_tab[c.index][c.corner] = c.vertex_ref;
				end
				OP_SMP: begin
					s = root_q16((65536 - longint'(c.u)) << 16);
					a = 65536 - s;
					b = (longint'(c.v) * s) >> 16;
					g = s - b;
					for (int k = 0; k < 3; k++) vr[k] = corner_tab[c.index][k];
					for (int k = 0; k < 3; k++) begin
						acc = g * pos_tab[vr[0]][k] + a * pos_tab[vr[1]][k]
							+ b * pos_tab[vr[2]][k];
						if (k == 0) p.px = floor16(acc);
						else if (k == 1) p.py = floor16(acc);
						else p.pz = floor16(acc);
						acc = normals_on ? g * nrm_tab[vr[0]][k] + a * nrm_tab[vr[1]][k]
							+ b * nrm_tab[vr[2]][k] : 0;
						if (k == 0) p.nx = floor16(acc);
						else if (k == 1) p.ny = floor16(acc);
						else p.nz = floor16(acc);
					end
					p.nv = normals_on;
					pending.push_back(p);
				end
				default: ;
			endcase
		endfunction

		function void report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endfunction

		function void check_point(point_t got);
			point_t w;
			if (pending.size() == 0) begin
				$display("mismatch: unexpected result beat");
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.px !== w.px) report("point_x", got.px, w.px);
			if (got.py !== w.py) report("point_y", got.py, w.py);
			if (got.pz !== w.pz) report("point_z", got.pz, w.pz);
			if (got.nx !== w.nx) report("normal_x", got.nx, w.nx);
			if (got.ny !== w.ny) report("normal_y", got.ny, w.ny);
			if (got.nz !== w.nz) report("normal_z", got.nz, w.nz);
			if (got.nv !== w.nv) report("normal_valid", got.nv, w.nv);
		endfunction
	endclass
endpackage

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Loads random meshes, samples points on written facets under random
// stalls on both channels, and checks every result against a predictor.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tps_pkg::*;
	import tps_tb_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;
	bit   no_idle;
	tps_req_if req ();
	tps_rsp_if rsp ();
	point_scoreboard sb;
	bit   vtx_done [4096];
	int   facet_list [$];

	triangle_point_sampler dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.req(req.source), .rsp(rsp.sink)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (rsp.valid && rsp.ready)
			sb.check_point({rsp.point_x, rsp.point_y, rsp.point_z, rsp.normal_x,
				rsp.normal_y, rsp.normal_z, rsp.normal_valid});
		rsp.ready <= no_idle || ($urandom_range(99) >= 6);
	end

	task automatic send(cmd_t c);
		while (!no_idle && $urandom_range(99) < 6) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.op <= c.op;
		req.index <= c.index;
		req.corner <= c.corner;
		req.vertex_ref <= c.vertex_ref;
		req.pos_x <= c.pos[0];
		req.pos_y <= c.pos[1];
		req.pos_z <= c.pos[2];
		req.nrm_x <= c.nrm[0];
		req.nrm_y <= c.nrm[1];
		req.nrm_z <= c.nrm[2];
		req.sample_u <= c.u;
		req.sample_v <= c.v;
		do @(posedge clk); while (!req.ready);
		sb.note_command(c);
	endtask

	function automatic cmd_t blank(logic [1:0] op, logic [11:0] idx);
		cmd_t c;
		c.op = op;
		c.index = idx;
		c.corner = 2'($urandom_range(3));
		c.vertex_ref = 12'($urandom);
		for (int k = 0; k < 3; k++) begin
			c.pos[k] = $urandom;
			c.nrm[k] = 16'($urandom);
		end
		c.u = 16'($urandom);
		c.v = 16'($urandom);
		return c;
	endfunction

	task automatic put_vertex(logic [11:0] idx, logic signed [31:0] p, logic signed [15:0] n,
		bit rnd);
		cmd_t c;
		c = blank(OP_VTX, idx);
		if (!rnd)
			for (int k = 0; k < 3; k++) begin
				c.pos[k] = p;
				c.nrm[k] = n;
			end
		send(c);
		vtx_done[idx] = 1;
	endtask

	task automatic put_facet(logic [11:0] idx, logic [11:0] a, logic [11:0] b,
		logic [11:0] d);
		cmd_t c;
		logic [11:0] refs [3];
		refs = '{a, b, d};
		for (int k = 0; k < 3; k++) begin
			c = blank(OP_FCT, idx);
			c.corner = 2'(k);
			c.vertex_ref = refs[k];
			send(c);
		end
		facet_list.push_back(idx);
	endtask

	task automatic sample(logic [11:0] idx, logic [15:0] u, logic [15:0] v);
		cmd_t c;
		c = blank(OP_SMP, idx);
		c.u = u;
		c.v = v;
		send(c);
	endtask

	task automatic settle();
		req.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_normals(bit on);
		settle();
		cfg_wr_en <= 1;
		cfg_wr_data <= on;
		@(posedge clk);
		sb.normals_on = on;
		cfg_wr_en <= 0;
	endtask

	function automatic logic [11:0] some_vertex();
		logic [11:0] i;
		do i = 12'($urandom); while (!vtx_done[i]);
		return i;
	endfunction

	initial begin
		cmd_t c;
		int n, sel;
		logic [11:0] f;
		sb = new();
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		no_idle = 0;
		req.valid = 0;
		req.op = 0; req.index = 0; req.corner = 0; req.vertex_ref = 0;
		req.pos_x = 0; req.pos_y = 0; req.pos_z = 0;
		req.nrm_x = 0; req.nrm_y = 0; req.nrm_z = 0;
		req.sample_u = 0; req.sample_v = 0;
		rsp.ready = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		put_vertex(0, 32'sh7fffffff, 16'sh7fff, 0);
		put_vertex(1, 32'sh80000000, 16'sh8000, 0);
		put_vertex(4095, 0, 0, 1);
		put_facet(0, 0, 1, 4095);
		put_facet(4095, 1, 0, 0);
		c = blank(OP_FCT, 5);
		c.corner = 3;
		send(c);
		send(blank(OP_NOP, 7));
		sample(0, 0, 0);
		sample(0, 16'hffff, 16'hffff);
		sample(4095, 0, 16'hffff);
		sample(0, 16'hffff, 0);
		set_normals(1);
		sample(0, 16'h8000, 16'h8000);
		sample(4095, 16'hffff, 16'hffff);
		for (int i = 0; i < 40; i++) put_vertex(12'($urandom), 0, 0, 1);
		for (int i = 0; i < 20; i++) put_facet(12'($urandom), some_vertex(), some_vertex(),
			some_vertex());
		n = 0;
		while (n < 700) begin
			if (n == 200) begin
				no_idle = 1;
				settle();
			end
			if (n == 350) no_idle = 0;
			if (n == 300) set_normals(0);
			if (n == 600) set_normals(1);
			sel = $urandom_range(99);
			if (sel < 75) begin
				f = 12'(facet_list[$urandom_range(facet_list.size() - 1)]);
				sample(f, 16'($urandom), 16'($urandom));
			end else if (sel < 85) begin
				put_vertex(12'($urandom), 0, 0, 1);
			end else if (sel < 95) begin
				put_facet(12'($urandom), some_vertex(), some_vertex(), some_vertex());
			end else begin
				c = blank($urandom_range(1) ? OP_NOP : OP_FCT, 12'($urandom));
				if (c.op == OP_FCT) c.corner = 3;
				send(c);
			end
			n++;
		end
		settle();
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/tps_pkg.sv
hw/rtl/tps_if.sv
hw/rtl/tps_ram.sv
hw/rtl/tps_isqrt.sv
hw/rtl/triangle_point_sampler.sv
tb/tps_tb_pkg.sv
tb/testbench.sv
